// ===== rtl/core/kptp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kptp_pkg
// Shared types, constants and lookup functions of the kern pitch token parser.
// ----------------------------------------------------------------------------
package kptp_pkg;

  // default saturation limit of the letter and accidental counters
  localparam int COUNT_LIMIT_DEF = 15;

  // entries in the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REST       = 2'd1,
    ST_NO_PITCH   = 2'd2,
    ST_BAD_OCTAVE = 2'd3
  } status_t;

  // what the subtoken has fixed so far
  typedef enum logic [1:0] {
    CS_NONE   = 2'd0,
    CS_LETTER = 2'd1,
    CS_REST   = 2'd2
  } class_stat_t;

  // base-40 offset of each diatonic class, C..B
  function automatic logic [5:0] class40(input logic [2:0] cls);
    logic [5:0] v;
    case (cls)
      3'd0:    v = 6'd0;
      3'd1:    v = 6'd6;
      3'd2:    v = 6'd12;
      3'd3:    v = 6'd17;
      3'd4:    v = 6'd23;
      3'd5:    v = 6'd29;
      3'd6:    v = 6'd35;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  // chromatic offset of each diatonic class, C..B
  function automatic logic [3:0] class12(input logic [2:0] cls);
    logic [3:0] v;
    case (cls)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd2;
      3'd2:    v = 4'd4;
      3'd3:    v = 4'd5;
      3'd4:    v = 4'd7;
      3'd5:    v = 4'd9;
      3'd6:    v = 4'd11;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // diatonic class from the low three bits of a letter, A..G or a..g
  function automatic logic [2:0] letter_class(input logic [2:0] lsb);
    logic [2:0] v;
    case (lsb)
      3'd1:    v = 3'd5;
      3'd2:    v = 3'd6;
      3'd3:    v = 3'd0;
      3'd4:    v = 3'd1;
      3'd5:    v = 3'd2;
      3'd6:    v = 3'd3;
      3'd7:    v = 3'd4;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kptp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kptp_front
// Takes characters, tracks the token state and on the last character pushes
// a classified token record (status, class, accidental, octave) to the queue.
// ----------------------------------------------------------------------------
module kptp_front
  import kptp_pkg::*;
#(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
  localparam int CW = $clog2(COUNT_LIMIT + 1),
  localparam int AW = CW + 1,
  localparam int OW = CW + 2,
  localparam int RW = 5 + AW + OW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_last_char,
  input  wire logic          q_full,
  output logic               q_push,
  output logic [RW-1:0]      q_rec
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_REST  = 8'h72;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_FLAT  = 8'h2D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_G  = 8'h67;

  localparam logic [CW-1:0]        CNT_MAX = CW'(COUNT_LIMIT);
  localparam logic signed [AW-1:0] ACC_MAX = AW'(COUNT_LIMIT);
  localparam logic signed [AW-1:0] ACC_MIN = -ACC_MAX;

  logic                done_r, done_nxt;
  class_stat_t         cs_r, cs_nxt;
  logic [2:0]          cls_r, cls_nxt;
  logic [CW-1:0]       up_r, up_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic                rest_r, rest_nxt;

  logic                accept;
  logic                is_upper;
  logic                is_lower;
  status_t             rec_status;
  logic [2:0]          rec_cls;
  logic signed [AW-1:0] rec_acc;
  logic signed [OW-1:0] rec_oct;

  // handshake
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_last_char;

  assign is_upper = (in_char_code >= CH_UP_A) && (in_char_code <= CH_UP_G);
  assign is_lower = (in_char_code >= CH_LO_A) && (in_char_code <= CH_LO_G);

  // per-character state update
  always_comb begin
    done_nxt = done_r;
    cs_nxt   = cs_r;
    cls_nxt  = cls_r;
    up_nxt   = up_r;
    lo_nxt   = lo_r;
    acc_nxt  = acc_r;
    rest_nxt = rest_r;
    if (!done_r) begin
      if (in_char_code == CH_SPACE) begin
        done_nxt = 1'b1;
      end else if (in_char_code == CH_REST) begin
        rest_nxt = 1'b1;
        if (cs_r == CS_NONE) cs_nxt = CS_REST;
      end else if (is_upper || is_lower) begin
        if (is_upper) begin
          if (up_r < CNT_MAX) up_nxt = up_r + 1'b1;
        end else if (lo_r < CNT_MAX) begin
          lo_nxt = lo_r + 1'b1;
        end
        if (cs_r == CS_NONE) begin
          cs_nxt  = CS_LETTER;
          cls_nxt = letter_class(in_char_code[2:0]);
        end
      end else if (in_char_code == CH_SHARP) begin
        if (acc_r < ACC_MAX) acc_nxt = acc_r + AW'(1);
      end else if (in_char_code == CH_FLAT) begin
        if (acc_r > ACC_MIN) acc_nxt = acc_r - AW'(1);
      end
    end
  end

  // classify the finished token
  always_comb begin
    rec_cls    = 3'd0;
    rec_acc    = '0;
    rec_oct    = '0;
    rec_status = ST_NO_PITCH;
    unique case (cs_nxt)
      CS_REST: rec_status = ST_REST;
      CS_LETTER: begin
        rec_cls = cls_nxt;
        rec_acc = acc_nxt;
        if (rest_nxt || (up_nxt != '0 && lo_nxt != '0)) begin
          rec_status = ST_BAD_OCTAVE;
        end else begin
          rec_status = ST_OK;
          if (up_nxt != '0) begin
            rec_oct = $signed(OW'(4)) - $signed({2'b00, up_nxt});
          end else begin
            rec_oct = $signed(OW'(3)) + $signed({2'b00, lo_nxt});
          end
        end
      end
      default: rec_status = ST_NO_PITCH;
    endcase
  end

  assign q_rec = {rec_status, rec_cls, rec_acc, rec_oct};

  // token state, cleared after each last character
  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      done_r <= 1'b0;
      cs_r   <= CS_NONE;
      cls_r  <= 3'd0;
      up_r   <= '0;
      lo_r   <= '0;
      acc_r  <= '0;
      rest_r <= 1'b0;
    end else if (accept) begin
      done_r <= done_nxt;
      cs_r   <= cs_nxt;
      cls_r  <= cls_nxt;
      up_r   <= up_nxt;
      lo_r   <= lo_nxt;
      acc_r  <= acc_nxt;
      rest_r <= rest_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kptp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kptp_queue
// Small register queue of token records between the front and the back.
// ----------------------------------------------------------------------------
module kptp_queue
  import kptp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== rtl/core/kptp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kptp_back
// Pops token records, forms the base-40, base-12, MIDI and base-7 numbers
// and holds the result item in the output register.
// ----------------------------------------------------------------------------
module kptp_back
  import kptp_pkg::*;
#(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
  localparam int CW = $clog2(COUNT_LIMIT + 1),
  localparam int AW = CW + 1,
  localparam int OW = CW + 2,
  localparam int RW = 5 + AW + OW,
  localparam int PW = CW + 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [RW-1:0] q_rec,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_diatonic_class,
  output logic signed [4:0]  out_accidental,
  output logic signed [5:0]  out_octave_number,
  output logic signed [10:0] out_base40_pitch,
  output logic signed [8:0]  out_base12_pitch,
  output logic signed [8:0]  out_midi_note,
  output logic signed [8:0]  out_base7_pitch
);

  status_t              rec_status;
  logic [2:0]           rec_cls;
  logic signed [AW-1:0] rec_acc;
  logic signed [OW-1:0] rec_oct;

  logic signed [PW-1:0] acc_x, oct_x, cls_x;
  logic signed [PW-1:0] b40, b12, midi, b7;

  logic                 valid_r;
  logic [1:0]           status_r;
  logic [2:0]           cls_r;
  logic signed [4:0]    acc_r;
  logic signed [5:0]    oct_r;
  logic signed [10:0]   b40_r;
  logic signed [8:0]    b12_r, midi_r, b7_r;

  // unpack the record
  assign rec_status = status_t'(q_rec[RW-1 -: 2]);
  assign rec_cls    = q_rec[RW-3 -: 3];
  assign rec_acc    = q_rec[OW +: AW];
  assign rec_oct    = q_rec[OW-1:0];

  assign acc_x = {{(PW-AW){rec_acc[AW-1]}}, rec_acc};
  assign oct_x = {{(PW-OW){rec_oct[OW-1]}}, rec_oct};
  assign cls_x = {{(PW-3){1'b0}}, rec_cls};

  // pitch numbers, zero unless the status is ok
  always_comb begin
    b40  = '0;
    b12  = '0;
    midi = '0;
    b7   = '0;
    if (rec_status == ST_OK) begin
      b40  = $signed({{(PW-6){1'b0}}, class40(rec_cls)}) + $signed(PW'(2)) + acc_x
             + (oct_x <<< 5) + (oct_x <<< 3);
      b12  = $signed({{(PW-4){1'b0}}, class12(rec_cls)}) + acc_x
             + (oct_x <<< 3) + (oct_x <<< 2);
      midi = b12 + $signed(PW'(12));
      b7   = cls_x + (oct_x <<< 3) - oct_x;
    end
  end

  // output register
  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= rec_status;
      cls_r    <= rec_cls;
      acc_r    <= acc_x[4:0];
      oct_r    <= oct_x[5:0];
      b40_r    <= b40[10:0];
      b12_r    <= b12[8:0];
      midi_r   <= midi[8:0];
      b7_r     <= b7[8:0];
    end
  end

  assign out_status         = status_r;
  assign out_diatonic_class = cls_r;
  assign out_accidental     = acc_r;
  assign out_octave_number  = oct_r;
  assign out_base40_pitch   = b40_r;
  assign out_base12_pitch   = b12_r;
  assign out_midi_note      = midi_r;
  assign out_base7_pitch    = b7_r;

endmodule
`default_nettype wire

// ===== rtl/core/kern_pitch_token_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kern_pitch_token_parser_unit
// Parses a kern pitch token one character per item and gives one result item
// per token with status, class, accidental, octave and pitch numbers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in_       input      in_valid / in_stall   char_code, last_char
//  out_      output     out_valid / out_stall status, class, accidental,
//                                             octave, pitch numbers
//
//  one character item per cycle while in_stall is low; the token counters are
//  registers; a result passes through the record queue and the output register
//  in_stall rises only when the two-entry record queue is full, i.e. when
//  out_stall has held results back
//  synchronous active-low reset clears the token state, the queue and
//  out_valid
// ----------------------------------------------------------------------------
module kern_pitch_token_parser_unit
  import kptp_pkg::*;
#(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_last_char,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_diatonic_class,
  output logic signed [4:0]  out_accidental,
  output logic signed [5:0]  out_octave_number,
  output logic signed [10:0] out_base40_pitch,
  output logic signed [8:0]  out_base12_pitch,
  output logic signed [8:0]  out_midi_note,
  output logic signed [8:0]  out_base7_pitch
);

  localparam int CW = $clog2(COUNT_LIMIT + 1);
  localparam int RW = 5 + (CW + 1) + (CW + 2);

  logic          q_push, q_pop, q_full, q_empty;
  logic [RW-1:0] push_rec, pop_rec;

  // character front
  kptp_front #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  // record queue
  kptp_queue #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_rec),
    .pop       (q_pop),
    .pop_data  (pop_rec),
    .full      (q_full),
    .empty     (q_empty)
  );

  // pitch back end
  kptp_back #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_rec              (pop_rec),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_diatonic_class (out_diatonic_class),
    .out_accidental     (out_accidental),
    .out_octave_number  (out_octave_number),
    .out_base40_pitch   (out_base40_pitch),
    .out_base12_pitch   (out_base12_pitch),
    .out_midi_note      (out_midi_note),
    .out_base7_pitch    (out_base7_pitch)
  );

`ifndef ASSERT_OFF
  // a finished token is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty)
    else $error("token record lost after push");

  // a new result appears only after a queue pop
  a_rise_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result without a popped record");

  // pitch numbers stay zero unless the status is ok
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_octave_number == 6'sd0 && out_base40_pitch == 11'sd0 &&
       out_base12_pitch == 9'sd0 && out_midi_note == 9'sd0 &&
       out_base7_pitch == 9'sd0))
    else $error("pitch numbers set on a non-ok result");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire
